>>> rtl/smoothed_peak_picker_macros.svh
// Assertion macros for the smoothed peak picker checker.
// No dependencies; the including scope must provide aclk and aresetn.
`ifndef SMOOTHED_PEAK_PICKER_MACROS_SVH
`define SMOOTHED_PEAK_PICKER_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SPP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// A stalled beat must keep its payload until it is taken.
`define SPP_ASSERT_HELD(lbl, vld, rdy, sig) \
    `SPP_ASSERT(lbl, ((vld) && !(rdy)) |=> $stable(sig), "payload changed during a stall")

`endif

>>> rtl/spp_pkg.sv
// Shared types, constants and filter coefficients for the smoothed peak picker.
// No dependencies; used by every module of the block.
package spp_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int MAX_RECORD   = 1048576;
    localparam int COUNT_BITS   = $clog2(MAX_RECORD) + 1;
    localparam int TAPS         = 5;
    localparam int COEF_BITS    = 8;
    localparam int ACC_BITS     = SAMPLE_BITS + COEF_BITS;
    localparam int STEP_COUNT   = 6;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((COUNT_BITS + 7) / 8) * 8;

    localparam logic KIND_PEAK = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef logic [COUNT_BITS-1:0]       count_t;
    typedef logic signed [ACC_BITS-1:0]  acc_t;
    typedef logic [TAPS-1:0][COEF_BITS-1:0] coef_row_t;

    // One smoothing step per tap set, then the end-of-record step.
    typedef enum logic [2:0] {
        STEP_SET0,
        STEP_SET1,
        STEP_SET2,
        STEP_SET3,
        STEP_SET4,
        STEP_END
    } step_t;

    // Work handed from the front end to the back end for one accepted sample.
    typedef struct packed {
        logic [TAPS-1:0][SAMPLE_BITS-1:0] win;   // index 0 is the oldest sample
        count_t                           count; // samples in the record so far
        logic [STEP_COUNT-1:0]            steps; // one bit per step_t code
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Coefficients scaled by 70; the edge fits are mirrored at the tail.
    function automatic coef_row_t tap_row(input step_t step);
        coef_row_t row;
        case (step)
            STEP_SET0: row = {-8'sd1,  8'sd4,  -8'sd6,  8'sd4,   8'sd69};
            STEP_SET1: row = { 8'sd4, -8'sd16,  8'sd24, 8'sd54,  8'sd4};
            STEP_SET2: row = {-8'sd6,  8'sd24,  8'sd34, 8'sd24, -8'sd6};
            STEP_SET3: row = { 8'sd4,  8'sd54,  8'sd24, -8'sd16, 8'sd4};
            STEP_SET4: row = { 8'sd69, 8'sd4,  -8'sd6,  8'sd4,  -8'sd1};
            default:   row = '0;
        endcase
        return row;
    endfunction

endpackage

>>> rtl/smoothed_peak_picker.sv
// Channel  Dir  Beat contents
// s_       in   tdata[23:0] sample, tlast marks the final sample of a record
// m_       out  tdata[20:0] peak position (0 on end beat), tuser[0] kind (1 = end)
//
// One sample beat per cycle while the job queue is not full; an accepted sample goes
// through the queue, the tap-product and sum and clamp stages to the result register.
// The back end runs one smoothing step per cycle unless a waiting result is stalled;
// the four-entry job queue absorbs the bursts of fits at the fifth and last samples.
// aresetn is synchronous, active low; a stalled result beat freezes only the back end.
module smoothed_peak_picker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [spp_pkg::S_TDATA_BITS-1:0]  s_tdata,  // [23:0] sample
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [spp_pkg::M_TDATA_BITS-1:0]  m_tdata,  // [20:0] position
    output logic                              m_tuser   // [0] kind
);

    spp_pkg::qstat_t qstat;
    spp_pkg::job_t   push_job, head_job;
    logic            push, pop;

    spp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .qstat    (qstat),
        .push     (push),
        .job      (push_job)
    );

    spp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head_job),
        .stat     (qstat)
    );

    spp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_job),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> rtl/spp_front.sv
// Front end: takes sample beats, keeps the five-sample window and the record count,
// and turns each beat into a job for the queue. Depends on spp_pkg.
module spp_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [spp_pkg::S_TDATA_BITS-1:0]    s_tdata,  // [23:0] sample
    input  logic                                s_tlast,
    input  spp_pkg::qstat_t                     qstat,
    output logic                                push,
    output spp_pkg::job_t                       job
);

    logic [spp_pkg::TAPS-1:0][spp_pkg::SAMPLE_BITS-1:0] window_reg, window_next, win_shift;
    spp_pkg::count_t count_reg, count_next, count_inc;

    assign s_tready = !qstat.full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < spp_pkg::TAPS - 1; i++) begin
            win_shift[i] = window_reg[i+1];
        end
        win_shift[spp_pkg::TAPS-1] = s_tdata[spp_pkg::SAMPLE_BITS-1:0];

        if (count_reg < spp_pkg::COUNT_BITS'(spp_pkg::MAX_RECORD)) begin
            count_inc = count_reg + spp_pkg::COUNT_BITS'(1);
        end else begin
            count_inc = count_reg;
        end

        // The fifth sample releases the two leading edge fits and the first centre fit.
        job.win   = win_shift;
        job.count = count_inc;
        job.steps = '0;
        if (count_reg == spp_pkg::COUNT_BITS'(4)) begin
            job.steps[spp_pkg::STEP_SET0] = 1'b1;
            job.steps[spp_pkg::STEP_SET1] = 1'b1;
            job.steps[spp_pkg::STEP_SET2] = 1'b1;
        end else if (count_reg >= spp_pkg::COUNT_BITS'(5)) begin
            job.steps[spp_pkg::STEP_SET2] = 1'b1;
        end
        if (s_tlast && count_inc >= spp_pkg::COUNT_BITS'(5)) begin
            job.steps[spp_pkg::STEP_SET3] = 1'b1;
            job.steps[spp_pkg::STEP_SET4] = 1'b1;
        end
        job.steps[spp_pkg::STEP_END] = s_tlast;

        window_next = window_reg;
        count_next  = count_reg;
        if (push) begin
            if (s_tlast) begin
                window_next = '0;
                count_next  = '0;
            end else begin
                window_next = win_shift;
                count_next  = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            count_reg  <= '0;
        end else begin
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/spp_queue.sv
// Four-entry job queue between the front end and the back end.
// Depends on spp_pkg for the job and status types.
module spp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  spp_pkg::job_t   push_job,
    input  logic            pop,
    output spp_pkg::job_t   head,
    output spp_pkg::qstat_t stat
);

    spp_pkg::job_t mem_reg [spp_pkg::QUEUE_DEPTH];
    logic [spp_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [spp_pkg::QPTR_BITS:0]   fill_reg, fill_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (fill_reg == (spp_pkg::QPTR_BITS + 1)'(spp_pkg::QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/spp_back.sv
// Back end: walks the steps of each queued job through a tap-product stage, a sum and
// clamp stage and a slope compare that loads the result register. Depends on spp_pkg.
module spp_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  spp_pkg::job_t                     head,
    input  spp_pkg::qstat_t                   qstat,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [spp_pkg::M_TDATA_BITS-1:0]  m_tdata,  // [20:0] position
    output logic                              m_tuser   // [0] kind
);

    typedef enum logic [1:0] {
        SLOPE_FLAT,
        SLOPE_UP,
        SLOPE_DOWN
    } slope_t;

    logic [spp_pkg::STEP_COUNT-1:0] done_reg, done_next, remaining, pick_bit;
    spp_pkg::step_t     cur_step;
    spp_pkg::coef_row_t row;
    logic               has_step, last_bit, en;

    logic               s1_valid_reg, s1_valid_next;
    spp_pkg::step_t     s1_step_reg;
    spp_pkg::count_t    s1_pos_reg, s1_pos_next;
    spp_pkg::acc_t      s1_prod_reg [spp_pkg::TAPS];
    spp_pkg::acc_t      prod_next   [spp_pkg::TAPS];

    logic               s2_valid_reg, s2_valid_next;
    spp_pkg::step_t     s2_step_reg;
    spp_pkg::count_t    s2_pos_reg;
    spp_pkg::acc_t      s2_value_reg, sum, value_next;

    spp_pkg::acc_t      hist_reg, hist_next;
    slope_t             slope_reg, slope_next, slope_now;
    logic               m_valid_reg, m_valid_next, emit;
    logic               m_kind_reg, m_kind_next;
    spp_pkg::count_t    m_pos_reg, m_pos_next;

    assign en       = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = spp_pkg::M_TDATA_BITS'(m_pos_reg);

    // Step selection: lowest pending step of the head job.
    always_comb begin
        remaining = head.steps & ~done_reg;
        pick_bit  = remaining & (~remaining + 1'b1);
        cur_step  = spp_pkg::STEP_SET0;
        for (int i = spp_pkg::STEP_COUNT - 1; i >= 0; i--) begin
            if (remaining[i]) begin
                cur_step = spp_pkg::step_t'(i);
            end
        end
        has_step = !qstat.empty && (remaining != '0);
        last_bit = ((remaining & (remaining - 1'b1)) == '0);
        pop      = en && !qstat.empty && last_bit;

        done_next = done_reg;
        if (en && !qstat.empty) begin
            done_next = last_bit ? '0 : (done_reg | pick_bit);
        end

        row = spp_pkg::tap_row(cur_step);
        for (int i = 0; i < spp_pkg::TAPS; i++) begin
            prod_next[i] = spp_pkg::acc_t'($signed(row[i])) *
                           spp_pkg::acc_t'($signed(head.win[i]));
        end
        // A peak is reported one position before the value that confirms it.
        s1_pos_next   = spp_pkg::count_t'(head.count + spp_pkg::COUNT_BITS'(cur_step)
                                          - spp_pkg::COUNT_BITS'(5));
        s1_valid_next = en ? has_step : s1_valid_reg;
        s2_valid_next = en ? s1_valid_reg : s2_valid_reg;
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < spp_pkg::TAPS; i++) begin
            sum = sum + s1_prod_reg[i];
        end
        value_next = (sum < 0) ? '0 : sum;
    end

    // Slope tracking and result formation.
    always_comb begin
        if (s2_value_reg > hist_reg) begin
            slope_now = SLOPE_UP;
        end else if (s2_value_reg < hist_reg) begin
            slope_now = SLOPE_DOWN;
        end else begin
            slope_now = SLOPE_FLAT;
        end

        emit        = 1'b0;
        m_kind_next = spp_pkg::KIND_PEAK;
        m_pos_next  = s2_pos_reg;
        hist_next   = hist_reg;
        slope_next  = slope_reg;
        if (s2_valid_reg && en) begin
            case (s2_step_reg)
                spp_pkg::STEP_END: begin
                    emit        = 1'b1;
                    m_kind_next = spp_pkg::KIND_END;
                    m_pos_next  = '0;
                    hist_next   = '0;
                    slope_next  = SLOPE_FLAT;
                end
                spp_pkg::STEP_SET0: begin
                    hist_next  = s2_value_reg;
                    slope_next = SLOPE_FLAT;
                end
                default: begin
                    emit       = (slope_reg == SLOPE_UP) && (slope_now == SLOPE_DOWN);
                    hist_next  = s2_value_reg;
                    slope_next = slope_now;
                end
            endcase
        end
        m_valid_next = en ? emit : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            hist_reg     <= '0;
            slope_reg    <= SLOPE_FLAT;
            m_valid_reg  <= 1'b0;
        end else begin
            done_reg     <= done_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            hist_reg     <= hist_next;
            slope_reg    <= slope_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_step_reg  <= cur_step;
            s1_pos_reg   <= s1_pos_next;
            s1_prod_reg  <= prod_next;
            s2_step_reg  <= s1_step_reg;
            s2_pos_reg   <= s1_pos_reg;
            s2_value_reg <= value_next;
            m_kind_reg   <= m_kind_next;
            m_pos_reg    <= m_pos_next;
        end
    end

endmodule

>>> rtl/spp_checker.sv
// Port-level checker for the smoothed peak picker, bound to the top level.
// Depends on spp_pkg and smoothed_peak_picker_macros.svh.
`include "smoothed_peak_picker_macros.svh"

module spp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [spp_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input logic                              m_tuser
);

    `SPP_ASSERT(m_valid_held, (m_tvalid && !m_tready) |=> m_tvalid, "result beat dropped while stalled")
    `SPP_ASSERT_HELD(m_data_held, m_tvalid, m_tready, m_tdata)
    `SPP_ASSERT(end_pos_zero, (m_tvalid && (m_tuser == spp_pkg::KIND_END)) |-> (m_tdata == '0), "end beat carries a position")
    `SPP_ASSERT(peak_pos_min, (m_tvalid && (m_tuser == spp_pkg::KIND_PEAK)) |-> (m_tdata >= spp_pkg::M_TDATA_BITS'(2)), "peak reported at an edge position")
    `SPP_ASSERT(quiet_after_reset, $rose(aresetn) |-> !m_tvalid, "result beat right after reset")

endmodule

bind smoothed_peak_picker spp_checker u_spp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb_smoothed_peak_picker.sv
// Self-checking testbench for smoothed_peak_picker: streams sample records in,
// predicts peak and end beats with its own Savitzky-Golay model, checks m_ beats.
// Depends on spp_pkg and the smoothed_peak_picker RTL.
`timescale 1ns / 1ps

module tb_smoothed_peak_picker;

    localparam int TOTAL_ITEMS = 460;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DIR_ROWS    = 27;

    typedef struct packed {
        logic            kind;
        spp_pkg::count_t position;
    } peak_beat_t;

    // One directed sample; pinned rows carry their result in end_only.
    typedef struct packed {
        logic [23:0] sample;
        logic        last;
        logic        pinned;
        logic        end_only;
    } stim_row_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [spp_pkg::S_TDATA_BITS-1:0] s_tdata = '0;
    logic                             s_tlast = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [spp_pkg::M_TDATA_BITS-1:0] m_tdata;
    logic                             m_tuser;

    peak_beat_t pending_peaks[$];
    peak_beat_t oldest_peak;
    int         mismatch_count = 0;
    int         idle_cycles = 0;
    bit         hold_request = 1'b0;
    bit         rx_quiet = 1'b0;

    // Filter state of the predictor: five samples, last smoothed value, count, slope.
    longint          sg_window [5];
    longint          sg_prev_smoothed;
    spp_pkg::count_t sg_count;
    int              sg_slope;
    longint          sg_taps [5][5] = '{
        '{ 69,   4, -6,   4, -1 },
        '{  4,  54, 24, -16,  4 },
        '{ -6,  24, 34,  24, -6 },
        '{  4, -16, 24,  54,  4 },
        '{ -1,   4, -6,   4, 69 }
    };

    stim_row_t dir_table [DIR_ROWS] = '{
        // A one-sample record only closes.
        '{24'h7FFFFF, 1'b1, 1'b1, 1'b1},
        // Four samples are too few to smooth, so only the end beat appears.
        '{24'h800000, 1'b0, 1'b1, 1'b0},
        '{24'h7FFFFF, 1'b0, 1'b1, 1'b0},
        '{24'h000000, 1'b0, 1'b1, 1'b0},
        '{24'hFFFFFF, 1'b1, 1'b1, 1'b1},
        // An isolated bump in the middle of the record.
        '{24'd0,      1'b0, 1'b0, 1'b0},
        '{24'd0,      1'b0, 1'b0, 1'b0},
        '{24'd0,      1'b0, 1'b0, 1'b0},
        '{24'd1000,   1'b0, 1'b0, 1'b0},
        '{24'd0,      1'b0, 1'b0, 1'b0},
        '{24'd0,      1'b1, 1'b0, 1'b0},
        // Full-scale alternation stresses the accumulator width.
        '{24'h7FFFFF, 1'b0, 1'b0, 1'b0},
        '{24'h800000, 1'b0, 1'b0, 1'b0},
        '{24'h7FFFFF, 1'b0, 1'b0, 1'b0},
        '{24'h800000, 1'b0, 1'b0, 1'b0},
        '{24'h7FFFFF, 1'b0, 1'b0, 1'b0},
        '{24'h800000, 1'b1, 1'b0, 1'b0},
        // A flat record is one long plateau and has no peak.
        '{24'd5,      1'b0, 1'b1, 1'b0},
        '{24'd5,      1'b0, 1'b1, 1'b0},
        '{24'd5,      1'b0, 1'b1, 1'b0},
        '{24'd5,      1'b0, 1'b1, 1'b0},
        '{24'd5,      1'b1, 1'b1, 1'b1},
        // Negative samples clamp to zero, which is flat as well.
        '{24'hFFFC18, 1'b0, 1'b1, 1'b0},
        '{24'hFFFBB4, 1'b0, 1'b1, 1'b0},
        '{24'hFFFC18, 1'b0, 1'b1, 1'b0},
        '{24'hFFFC7C, 1'b0, 1'b1, 1'b0},
        '{24'hFFFC18, 1'b1, 1'b1, 1'b1}
    };

    smoothed_peak_picker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic longint smoothed_at(input int set);
        longint acc;
        acc = 0;
        for (int i = 0; i < 5; i++) begin
            acc += sg_taps[set][i] * sg_window[i];
        end
        return (acc < 0) ? 0 : acc;
    endfunction

    function automatic void clear_filter();
        for (int i = 0; i < 5; i++) begin
            sg_window[i] = 0;
        end
        sg_prev_smoothed = 0;
        sg_count = '0;
        sg_slope = 0;
    endfunction

    // A falling step right after a rising one puts a peak one position back.
    function automatic void take_smoothed(input longint v, input spp_pkg::count_t pos,
                                          input bit first, ref peak_beat_t peaks[$]);
        int step_sign;
        if (first) begin
            sg_slope = 0;
        end else begin
            step_sign = (v > sg_prev_smoothed) ? 1 : ((v < sg_prev_smoothed) ? -1 : 0);
            if (sg_slope == 1 && step_sign == -1) begin
                peaks.insert(peaks.size(),
                             peak_beat_t'{spp_pkg::KIND_PEAK, spp_pkg::count_t'(pos - 1)});
            end
            sg_slope = step_sign;
        end
        sg_prev_smoothed = v;
    endfunction

    function automatic void predict_peaks(input logic [23:0] raw, input logic last,
                                          ref peak_beat_t peaks[$]);
        spp_pkg::count_t taken;
        taken = sg_count;
        for (int i = 0; i < 4; i++) begin
            sg_window[i] = sg_window[i + 1];
        end
        sg_window[4] = longint'($signed(raw));
        if (sg_count < spp_pkg::MAX_RECORD) begin
            sg_count++;
        end
        if (taken == 4) begin
            take_smoothed(smoothed_at(0), spp_pkg::count_t'(1), 1'b1, peaks);
            take_smoothed(smoothed_at(1), spp_pkg::count_t'(2), 1'b0, peaks);
            take_smoothed(smoothed_at(2), spp_pkg::count_t'(3), 1'b0, peaks);
        end else if (taken >= 5) begin
            take_smoothed(smoothed_at(2), spp_pkg::count_t'(sg_count - 2), 1'b0, peaks);
        end
        if (last) begin
            if (sg_count >= 5) begin
                take_smoothed(smoothed_at(3), spp_pkg::count_t'(sg_count - 1), 1'b0, peaks);
                take_smoothed(smoothed_at(4), sg_count, 1'b0, peaks);
            end
            peaks.insert(peaks.size(), peak_beat_t'{spp_pkg::KIND_END, spp_pkg::count_t'(0)});
            clear_filter();
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offers one sample beat after a random gap and books its results on acceptance.
    task automatic send_sample(input logic [23:0] smp, input logic last, input bit pinned,
                               input bit end_only, input bit quiet);
        peak_beat_t found[$];
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_peaks(smp, last, found);
        if (pinned) begin
            found.delete();
            if (end_only) begin
                found.insert(found.size(),
                             peak_beat_t'{spp_pkg::KIND_END, spp_pkg::count_t'(0)});
            end
        end
        foreach (found[i]) begin
            pending_peaks.insert(pending_peaks.size(), found[i]);
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_peaks.size() != 0);
    endtask

    // Result side: random stalls, quiet stretches, and one long hold-off on request.
    initial begin
        int gap;
        forever begin
            gap = rx_quiet ? 0 : $urandom_range(0, 14);
            if (hold_request) begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && !hold_request);
            if ($urandom_range(0, 24) == 0) begin
                rx_quiet = !rx_quiet;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_peaks.size() == 0) begin
                report_mismatch("unexpected result beat, position", m_tdata, 0);
            end else begin
                oldest_peak = pending_peaks.pop_front();
                if (m_tuser !== oldest_peak.kind) begin
                    report_mismatch("kind", m_tuser, oldest_peak.kind);
                end
                if (m_tdata !== spp_pkg::M_TDATA_BITS'(oldest_peak.position)) begin
                    report_mismatch("position", m_tdata, oldest_peak.position);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int          items_sent;
        int          record_no;
        int          len;
        int          shape;
        int          period;
        int          half;
        int          ramp_offset;
        longint      amp;
        logic [23:0] held;
        logic [23:0] smp;
        bit          quiet;

        clear_filter();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_sample(dir_table[r].sample, dir_table[r].last, dir_table[r].pinned,
                        dir_table[r].end_only, 1'b0);
        end
        items_sent = DIR_ROWS;
        wait_for_drain();

        record_no = 0;
        held = '0;
        while (items_sent < TOTAL_ITEMS) begin
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            shape  = $urandom_range(0, 3);
            period = $urandom_range(3, 16);
            amp    = $urandom_range(0, 4000000);
            quiet  = ($urandom_range(0, 3) == 0);
            if (record_no == 4) begin
                // The receiver stalls while a long burst fills the job queue.
                hold_request = 1'b1;
                len   = 60;
                quiet = 1'b1;
            end
            if (record_no == 10) begin
                wait_for_drain();
            end
            for (int i = 0; i < len; i++) begin
                case (shape)
                    0: smp = 24'($urandom);
                    1: smp = 24'($urandom_range(0, 2000) - 1000);
                    2: begin
                        if (i == 0 || $urandom_range(0, 3) == 0) begin
                            held = 24'($urandom);
                        end
                        smp = held;
                    end
                    default: begin
                        half = period / 2;
                        ramp_offset = (i % period) - half;
                        if (ramp_offset < 0) begin
                            ramp_offset = -ramp_offset;
                        end
                        smp = 24'(amp * (half - ramp_offset) / half
                                  + $urandom_range(0, 63) - 32);
                    end
                endcase
                send_sample(smp, i == len - 1, 1'b0, 1'b0, quiet);
            end
            items_sent += len;
            record_no++;
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_peaks.size() != 0);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
